### rtl/core/bm3_pkg.sv
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared types and constants of the 3x3x3 box mean block.
// ----------------------------------------------------------------------------
package bm3_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;

  // output queue geometry
  localparam int OQ_AW    = 3;
  localparam int OQ_DEPTH = 1 << OQ_AW;
  localparam int OQ_CW    = OQ_AW + 1;

  typedef struct packed {
    logic [15:0] mean_word;
    logic        last_voxel;
  } result_t;

  typedef struct packed {
    logic    vld;
    result_t res;
  } oq_push_t;

endpackage

### rtl/core/box_mean_3x3x3_volume.sv
// ----------------------------------------------------------------------------
// box_mean_3x3x3_volume
// Streaming 3x3x3 box mean over a raster-order volume of 16-bit voxels.
// ----------------------------------------------------------------------------
//  channel | ports                                  | role
//  --------+----------------------------------------+--------------------------
//  in      | in_valid in_stall in_voxel_word        | voxel beats, big-endian
//  out     | out_valid out_stall out_mean_word      | interior voxel means,
//          | out_last_voxel                         | big-endian
//  cfg     | cfg_we cfg_index cfg_data              | size_x, size_y, size_z
//
// One voxel beat per cycle sustained while in_stall is low; each beat does one
// read-modify-write of the plane memory and of the line memory, a result is
// pushed into the queue from stage five. Reset clears positions and the
// pipeline, loads default sizes; memories are not cleared and need no clearing
// pass. in_stall rises when eight beats are in the pipeline or result queue.
// ----------------------------------------------------------------------------
module box_mean_3x3x3_volume
  import bm3_pkg::*;
#(
  parameter int MAX_X = 512,
  parameter int MAX_Y = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_voxel_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_mean_word,
  output logic        out_last_voxel,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int XW      = $clog2(MAX_X);
  localparam int YW      = $clog2(MAX_Y);
  localparam int PD      = MAX_X * MAX_Y;
  localparam int PAW     = $clog2(PD);
  localparam int S3W     = 18;
  localparam int VSW     = 20;
  localparam int TW      = 21;
  localparam int NW      = 22;
  localparam int MW      = 23;
  localparam int PW      = NW + MW;
  localparam int DIV_SH  = 28;
  localparam logic [MW-1:0] DIV_MULT = 23'd4971027;  // ceil(2^28 / 54)
  localparam logic [NW-1:0] RND_BIAS = 22'd27;
  localparam int XRST    = (MAX_X < 512) ? MAX_X : 512;
  localparam int YRST    = (MAX_Y < 512) ? MAX_Y : 512;
  localparam logic [XW-1:0] XLAST_RST = XW'(XRST - 1);
  localparam logic [YW-1:0] YLAST_RST = YW'(YRST - 1);
  localparam logic [11:0]   ZLAST_RST = 12'd511;

  function automatic logic [15:0] swap16(input logic [15:0] w);
    return {w[7:0], w[15:8]};
  endfunction

  // handshakes
  logic in_acc;
  logic out_pop;
  logic drop5;

  // configuration and position
  logic [XW-1:0]  xlast_r, xlast_nxt;
  logic [YW-1:0]  ylast_r, ylast_nxt;
  logic [11:0]    zlast_r, zlast_nxt;
  logic [XW-1:0]  x_r, x_nxt;
  logic [YW-1:0]  y_r, y_nxt;
  logic [11:0]    z_r, z_nxt;
  logic [PAW-1:0] paddr_r, paddr_nxt;
  logic           emit0;
  logic           last0;

  // memories
  logic [31:0]      pl_rdata;
  logic [31:0]      pl_wdata;
  logic [2*S3W-1:0] ln_rdata;
  logic [2*S3W-1:0] ln_wdata;

  // pipeline
  logic           v1_r, v2_r, v3_r, v4_r, v5_r;
  logic           emit1_r, emit2_r, emit3_r, emit4_r, emit5_r;
  logic           last1_r, last2_r, last3_r, last4_r, last5_r;
  logic [15:0]    word1_r;
  logic [PAW-1:0] paddr1_r;
  logic [XW-1:0]  x1_r;
  logic [S3W-1:0] s3;
  logic [S3W-1:0] s3_2_r, r1_2_r, r2_2_r;
  logic [VSW-1:0] vs;
  logic [VSW-1:0] c0_r, c1_r, c2_r;
  logic [TW-1:0]  total;
  logic [NW-1:0]  n4_r, n_nxt;
  logic [PW-1:0]  prod5_r, prod_nxt;

  logic [OQ_CW-1:0] occ_r, occ_nxt;
  oq_push_t         oq_push;
  result_t          oq_head;

  assign in_acc   = in_valid & ~in_stall;
  assign out_pop  = out_valid & ~out_stall;
  assign in_stall = (occ_r >= OQ_CW'(OQ_DEPTH));

  // ---------------------------------------------------------------- config
  always_comb begin
    logic [12:0] cx;
    logic [12:0] cy;
    logic [11:0] cz;
    cx = {3'b0, cfg_data[9:0]};
    cy = {3'b0, cfg_data[9:0]};
    cz = cfg_data;
    if (cx < 13'd3) begin
      cx = 13'd3;
    end else if (cx > 13'(MAX_X)) begin
      cx = 13'(MAX_X);
    end
    if (cy < 13'd3) begin
      cy = 13'd3;
    end else if (cy > 13'(MAX_Y)) begin
      cy = 13'(MAX_Y);
    end
    if (cz < 12'd3) begin
      cz = 12'd3;
    end
    xlast_nxt = xlast_r;
    ylast_nxt = ylast_r;
    zlast_nxt = zlast_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE_X: xlast_nxt = XW'(cx - 13'd1);
        CFG_SIZE_Y: ylast_nxt = YW'(cy - 13'd1);
        CFG_SIZE_Z: zlast_nxt = cz - 12'd1;
        default:    ;
      endcase
    end
  end

  // -------------------------------------------------------------- position
  always_comb begin
    emit0     = (x_r >= XW'(2)) && (y_r >= YW'(2)) && (z_r >= 12'd2);
    last0     = (x_r == xlast_r) && (y_r == ylast_r) && (z_r == zlast_r);
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    paddr_nxt = paddr_r;
    if (cfg_we) begin
      x_nxt     = '0;
      y_nxt     = '0;
      z_nxt     = '0;
      paddr_nxt = '0;
    end else if (in_acc) begin
      paddr_nxt = paddr_r + PAW'(1);
      if (x_r == xlast_r) begin
        x_nxt = '0;
        if (y_r == ylast_r) begin
          y_nxt     = '0;
          paddr_nxt = '0;
          z_nxt     = (z_r == zlast_r) ? 12'd0 : z_r + 12'd1;
        end else begin
          y_nxt = y_r + YW'(1);
        end
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xlast_r <= XLAST_RST;
      ylast_r <= YLAST_RST;
      zlast_r <= ZLAST_RST;
      x_r     <= '0;
      y_r     <= '0;
      z_r     <= '0;
      paddr_r <= '0;
    end else begin
      xlast_r <= xlast_nxt;
      ylast_r <= ylast_nxt;
      zlast_r <= zlast_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      paddr_r <= paddr_nxt;
    end
  end

  // -------------------------------------------------------------- memories
  // plane entry holds {plane z-1, plane z-2} at one (x, y)
  bm3_ram #(
    .WIDTH (32),
    .DEPTH (PD)
  ) u_plane_ram (
    .clk   (clk),
    .we    (v1_r),
    .waddr (paddr1_r),
    .wdata (pl_wdata),
    .re    (in_acc),
    .raddr (paddr_r),
    .rdata (pl_rdata)
  );

  // line entry holds the three-plane column sums of rows y-1 and y-2
  bm3_ram #(
    .WIDTH (2 * S3W),
    .DEPTH (MAX_X)
  ) u_line_ram (
    .clk   (clk),
    .we    (v1_r),
    .waddr (x1_r),
    .wdata (ln_wdata),
    .re    (in_acc),
    .raddr (x_r),
    .rdata (ln_rdata)
  );

  // -------------------------------------------------------------- pipeline
  assign s3       = {2'b0, pl_rdata[31:16]} + {2'b0, pl_rdata[15:0]} + {2'b0, word1_r};
  assign pl_wdata = {word1_r, pl_rdata[31:16]};
  assign ln_wdata = {s3, ln_rdata[2*S3W-1:S3W]};

  assign vs       = {2'b0, s3_2_r} + {2'b0, r1_2_r} + {2'b0, r2_2_r};
  assign total    = {1'b0, c0_r} + {1'b0, c1_r} + {1'b0, c2_r};
  assign n_nxt    = {total, 1'b0} + RND_BIAS;
  assign prod_nxt = PW'(n4_r) * PW'(DIV_MULT);

  always_ff @(posedge clk) begin
    word1_r  <= swap16(in_voxel_word);
    paddr1_r <= paddr_r;
    x1_r     <= x_r;
    emit1_r  <= emit0;
    last1_r  <= last0;

    s3_2_r  <= s3;
    r1_2_r  <= ln_rdata[2*S3W-1:S3W];
    r2_2_r  <= ln_rdata[S3W-1:0];
    emit2_r <= emit1_r;
    last2_r <= last1_r;

    // horizontal window: last three columns of the current row
    if (v2_r) begin
      c0_r <= vs;
      c1_r <= c0_r;
      c2_r <= c1_r;
    end
    emit3_r <= emit2_r;
    last3_r <= last2_r;

    n4_r    <= n_nxt;
    emit4_r <= emit3_r;
    last4_r <= last3_r;

    prod5_r <= prod_nxt;
    emit5_r <= emit4_r;
    last5_r <= last4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      occ_r <= '0;
    end else begin
      v1_r  <= in_acc;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      occ_r <= occ_nxt;
    end
  end

  // beats in flight plus queued results; boundary beats leave at stage five
  assign drop5   = v5_r & ~emit5_r;
  assign occ_nxt = occ_r + OQ_CW'(in_acc) - OQ_CW'(drop5) - OQ_CW'(out_pop);

  // ---------------------------------------------------------------- output
  always_comb begin
    oq_push.vld            = v5_r & emit5_r;
    oq_push.res.mean_word  = swap16(prod5_r[DIV_SH+15:DIV_SH]);
    oq_push.res.last_voxel = last5_r;
  end

  bm3_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .pop   (out_pop),
    .vld   (out_valid),
    .head  (oq_head)
  );

  assign out_mean_word  = oq_head.mean_word;
  assign out_last_voxel = oq_head.last_voxel;

endmodule

### rtl/core/bm3_ram.sv
// ----------------------------------------------------------------------------
// bm3_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bm3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/bm3_outq.sv
// ----------------------------------------------------------------------------
// bm3_outq
// Result queue between the mean pipeline and the output channel.
// ----------------------------------------------------------------------------
module bm3_outq
  import bm3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  oq_push_t push,
  input  logic     pop,
  output logic     vld,
  output result_t  head
);

  result_t            q_r [OQ_DEPTH];
  logic [OQ_AW-1:0]   wp_r;
  logic [OQ_AW-1:0]   rp_r;
  logic [OQ_CW-1:0]   cnt_r;

  assign vld  = (cnt_r != '0);
  assign head = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push.vld) begin
      q_r[wp_r] <= push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push.vld) begin
        wp_r <= wp_r + OQ_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + OQ_AW'(1);
      end
      cnt_r <= cnt_r + OQ_CW'(push.vld) - OQ_CW'(pop);
    end
  end

endmodule

### sim/bm3_checker.sv
// ----------------------------------------------------------------------------
// bm3_checker
// Watches the voxel, mean and register ports of the box mean block, predicts
// every mean beat from the voxel stream and compares field by field.
// ----------------------------------------------------------------------------
module bm3_checker
  import bm3_pkg::*;
#(
  parameter int MAX_X = 512,
  parameter int MAX_Y = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_voxel_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_mean_word,
  input  logic        out_last_voxel,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          fail_count,
  output int          mean_backlog,
  output int          means_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PLANE_WORDS = MAX_X * MAX_Y;
  localparam int MAX_Z       = 4095;
  localparam int X_RESET     = (MAX_X < 512) ? MAX_X : 512;
  localparam int Y_RESET     = (MAX_Y < 512) ? MAX_Y : 512;

  // last three planes of the volume, plane z kept in slot z mod 3
  bit [15:0]   plane_ring [3 * PLANE_WORDS];
  int unsigned col_at, row_at, plane_at;
  int unsigned span_x, span_y, span_z;
  result_t     mean_q [$];

  function automatic int unsigned ring_addr(int unsigned z, int unsigned y, int unsigned x);
    return (z % 3) * PLANE_WORDS + y * MAX_X + x;
  endfunction

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    return (v < 3) ? 3 : ((v > hi) ? hi : v);
  endfunction

  always @(posedge clk) begin
    logic [15:0] sample;
    logic [15:0] mean_val;
    int unsigned total;
    int unsigned dz, dy, dx;
    result_t     want;

    if (!rst_n) begin
      span_x   = X_RESET;
      span_y   = Y_RESET;
      span_z   = 512;
      col_at   = 0;
      row_at   = 0;
      plane_at = 0;
      mean_q.delete();
    end else begin
      // outgoing beat first, so it never pairs with a mean predicted at this edge
      if (out_valid && !out_stall) begin
        means_seen++;
        if (mean_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] mean beat with none expected: mean_word=%h last_voxel=%b",
                     $time, out_mean_word, out_last_voxel);
        end else begin
          want = mean_q.pop_front();
          if (out_mean_word !== want.mean_word || out_last_voxel !== want.last_voxel) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] mean beat %0d: expected mean_word=%h last_voxel=%b, got %h %b",
                       $time, means_seen, want.mean_word, want.last_voxel,
                       out_mean_word, out_last_voxel);
          end
        end
      end

      // any write, the spare index too, restarts the volume
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIZE_X: span_x = clamp_size(cfg_data[9:0], MAX_X);
          CFG_SIZE_Y: span_y = clamp_size(cfg_data[9:0], MAX_Y);
          CFG_SIZE_Z: span_z = clamp_size(cfg_data, MAX_Z);
          default: ;
        endcase
        col_at   = 0;
        row_at   = 0;
        plane_at = 0;
      end

      if (in_valid && !in_stall) begin
        sample = {in_voxel_word[7:0], in_voxel_word[15:8]};
        plane_ring[ring_addr(plane_at, row_at, col_at)] = sample;
        // this voxel closes the window around (x-1, y-1, z-1)
        if (col_at >= 2 && row_at >= 2 && plane_at >= 2) begin
          total = 0;
          for (dz = 0; dz < 3; dz++)
            for (dy = 0; dy < 3; dy++)
              for (dx = 0; dx < 3; dx++)
                total += plane_ring[ring_addr(plane_at - dz, row_at - dy, col_at - dx)];
          mean_val        = 16'((2 * total + 27) / 54);
          want.mean_word  = {mean_val[7:0], mean_val[15:8]};
          want.last_voxel = (col_at + 1 == span_x) && (row_at + 1 == span_y) &&
                            (plane_at + 1 == span_z);
          mean_q.push_back(want);
        end
        col_at++;
        if (col_at >= span_x) begin
          col_at = 0;
          row_at++;
          if (row_at >= span_y) begin
            row_at = 0;
            plane_at++;
            if (plane_at >= span_z) plane_at = 0;
          end
        end
      end
    end
    mean_backlog = mean_q.size();
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives voxel volumes and register writes into the 3x3x3 box mean block:
// directed rounding, clamping and restart cases, many small random volumes
// under changing idle and stall patterns, then the first planes of the
// deepest volume.
// ----------------------------------------------------------------------------
module tb_top
  import bm3_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MAX_X         = 512;
  localparam int         MAX_Y         = 512;
  localparam int         RANDOM_VOXELS = 1650;
  localparam int         SETTLE        = 12;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam logic [1:0] CFG_SPARE     = 2'd3;

  typedef enum int {QUIET, SEND_GAPS, RECV_STALLS, BOTH_IDLE} idling_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_voxel_word;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_mean_word;
  logic        out_last_voxel;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  int          fail_count;
  int          mean_backlog;
  int          means_seen;
  int          idle_pct;
  int          stall_pct;
  int          voxels_sent;
  int          reg_writes;
  int unsigned cycle_count;

  box_mean_3x3x3_volume #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_dut (.*);

  bm3_checker #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d means outstanding", cycle_count, mean_backlog);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic set_idling(input idling_e mode);
    case (mode)
      QUIET:       begin idle_pct = 0;  stall_pct = 0;  end
      SEND_GAPS:   begin idle_pct = 46; stall_pct = 0;  end
      RECV_STALLS: begin idle_pct = 0;  stall_pct = 46; end
      BOTH_IDLE:   begin idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  function automatic logic [15:0] pick_voxel();
    case ($urandom_range(9))
      0:       return 16'hffff;
      1:       return 16'h0000;
      2:       return {8'h00, 8'($urandom)};
      3:       return {8'($urandom), 8'h00};
      default: return 16'($urandom);
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic push_voxel(input logic [15:0] word);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_voxel_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    voxels_sent++;
    @(negedge clk);
  endtask

  task automatic stream_voxels(input int count);
    repeat (count) push_voxel(pick_voxel());
  endtask

  // hold the sender until every mean is out, then let trailing beats clear
  task automatic drain_block();
    in_valid <= 1'b0;
    while (mean_backlog != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    reg_writes++;
    @(negedge clk);
  endtask

  initial begin
    int sx, sy, sz, span, cut, roll, base, run_count;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_voxel_word = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SIZE_X;
    cfg_data      = '0;
    set_idling(QUIET);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // smallest volume, sizes reached through clamping and masking
    write_reg(CFG_SIZE_X, 12'd0);
    write_reg(CFG_SIZE_Y, 12'h403);
    write_reg(CFG_SIZE_Z, 12'd1);
    repeat (27) push_voxel(16'hffff);
    // volume wraps: a sum of fourteen rounds up to one
    repeat (14) push_voxel(16'h0100);
    repeat (13) push_voxel(16'h0000);
    // cut short, restart through the spare index, a sum of thirteen rounds down
    repeat (5) push_voxel(16'h1234);
    drain_block();
    write_reg(CFG_SPARE, 12'h000);
    repeat (13) push_voxel(16'h0100);
    repeat (14) push_voxel(16'h0000);

    base      = voxels_sent;
    run_count = 0;
    while (voxels_sent < base + RANDOM_VOXELS) begin
      if ($urandom_range(7) == 0) begin
        sx = $urandom_range(11, 40);
        sy = 3;
        sz = 3;
      end else begin
        sx = $urandom_range(3, 10);
        sy = $urandom_range(3, 6);
        sz = $urandom_range(3, 5);
      end
      drain_block();
      set_idling(idling_e'(run_count % 4));
      write_reg(CFG_SIZE_X, 12'(sx));
      write_reg(CFG_SIZE_Y, 12'(sy));
      write_reg(CFG_SIZE_Z, 12'(sz));
      span = sx * sy * sz;
      roll = $urandom_range(9);
      if (roll == 0) begin
        stream_voxels($urandom_range(1, span - 1));
        drain_block();
        write_reg(CFG_SPARE, 12'($urandom));
      end else if (roll < 3) begin
        cut = $urandom_range(1, span - 1);
        stream_voxels(cut);
        drain_block();
        stream_voxels(span - cut);
      end else begin
        stream_voxels(span * $urandom_range(1, 2));
      end
      run_count++;
    end

    // deepest volume, only its first planes
    drain_block();
    set_idling(RECV_STALLS);
    write_reg(CFG_SIZE_X, 12'd3);
    write_reg(CFG_SIZE_Y, 12'd3);
    write_reg(CFG_SIZE_Z, 12'hfff);
    stream_voxels(36);
    drain_block();

    $display("sent %0d voxel beats in %0d random volumes plus directed and deep-volume runs",
             voxels_sent, run_count);
    $display("%0d register writes, %0d mean beats checked, %0d mismatches",
             reg_writes, means_seen, fail_count);
    if (fail_count == 0 && mean_backlog == 0) begin
      $display("== PASS ==");
    end else begin
      if (mean_backlog != 0) $display("%0d expected means never arrived", mean_backlog);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
